// ===== hw/rtl/rv32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_pkg: shared types and constants for the RV32IM execute unit
// Operation codes, register file sizes and sequencer states.
// ----------------------------------------------------------------------------
package rv32_pkg;

    localparam int NumRegs = 32;
    localparam int RegIdxW = 5;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLL = 6'd2, OP_SLT = 6'd3, OP_SLTU = 6'd4,
        OP_XOR = 6'd5, OP_SRL = 6'd6, OP_SRA = 6'd7, OP_OR = 6'd8, OP_AND = 6'd9,
        OP_ADDI = 6'd10, OP_SLTI = 6'd11, OP_SLTIU = 6'd12, OP_XORI = 6'd13,
        OP_ORI = 6'd14, OP_ANDI = 6'd15, OP_SLLI = 6'd16, OP_SRLI = 6'd17,
        OP_SRAI = 6'd18, OP_LUI = 6'd19, OP_AUIPC = 6'd20, OP_JAL = 6'd21,
        OP_JALR = 6'd22, OP_BEQ = 6'd23, OP_BNE = 6'd24, OP_BLT = 6'd25,
        OP_BGE = 6'd26, OP_BLTU = 6'd27, OP_BGEU = 6'd28, OP_MUL = 6'd29,
        OP_MULH = 6'd30, OP_MULHSU = 6'd31, OP_MULHU = 6'd32, OP_DIV = 6'd33,
        OP_DIVU = 6'd34, OP_REM = 6'd35, OP_REMU = 6'd36
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_ITER, ST_FIX, ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/rv32im_execute_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core: sequential RV32IM integer execute unit
// Register file, program counter and a shared shift-add / restoring divide unit.
// ----------------------------------------------------------------------------
// One instruction per item. After an item is accepted, the sequencer reads
// operand A and then operand B (ST_READ), executes (ST_EXEC) and then offers
// the result (ST_OUT); the block is ready again in the cycle after the result
// is taken, so it takes no new item before it is through with the last. Multiply
// and divide iterate one bit per cycle through a shared 33-bit add/subtract
// unit (ST_ITER), followed by a sign fix step (ST_FIX). The register file is a
// 32-entry memory read one operand per cycle, cleared by reset through valid
// bits. Writing start_pc loads the program counter at once.
module rv32im_execute_unit_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // req_type[5:0], dest_reg[10:6], src_reg_a[15:11], src_reg_b[20:16],
    // immediate[52:21], zero fill to 56 bits
    input  logic [55:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // write_value[31:0], write_done[32], next_pc[64:33], branch_taken[65],
    // zero fill to 72 bits
    output logic [71:0]         m_tdata
);
    import rv32_pkg::*;

    state_t state_reg, state_next;

    // Register file with per-entry valid bits so reset reads as zero.
    logic [31:0] rf_mem [NumRegs];
    logic [NumRegs-1:0] rf_vld_reg;
    logic [31:0] rf_q;
    logic [RegIdxW-1:0] rf_raddr;
    logic rf_we;

    logic [31:0] pc_reg;
    logic [5:0]  op_reg;
    logic [4:0]  rd_reg, rs2_reg, a_idx_reg;
    logic [31:0] imm_reg, a_reg, b_reg;
    logic        rd_b_reg;  // second read cycle flag
    logic [5:0]  cnt_reg;

    // Shared iteration unit registers.
    logic [63:0] acc_reg;   // product or {remainder, quotient}
    logic [31:0] mb_reg;
    logic        neg_reg, sa_reg, sb_reg;

    logic [31:0] val_reg, npc_reg;
    logic        wdone_reg, taken_reg;

    always_ff @(posedge aclk) begin
        rf_q <= rf_mem[rf_raddr];
        if (rf_we) begin
            rf_mem[rd_reg] <= val_reg;
        end
    end

    assign rf_raddr = (state_reg == ST_IDLE) ? s_tdata[15:11] : rs2_reg;
    assign rf_we    = (state_reg == ST_OUT) && wdone_reg && m_tready;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_READ;
            ST_READ: if (rd_b_reg) state_next = ST_EXEC;
            ST_EXEC: begin
                if (op_reg inside {[OP_MUL:OP_REMU]}) state_next = ST_ITER;
                else state_next = ST_OUT;
            end
            ST_ITER: if (cnt_reg == 6'd31) state_next = ST_FIX;
            ST_FIX:  state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Operand values, gated by valid bits.
    logic [31:0] rf_val;
    logic [4:0]  rsel;
    logic        rd_is_a;
    assign rd_is_a = !rd_b_reg;
    assign rsel    = rd_is_a ? a_idx_reg : rs2_reg;
    assign rf_val = (rsel == '0 || !rf_vld_reg[rsel]) ? 32'd0 : rf_q;

    // Execute combinational results.
    logic [31:0] opb, alu_v, seq, add_v;
    logic [3:0]  alu_op;
    logic        lts, ltu, cond, is_alu;
    always_comb begin
        opb = (op_reg inside {[OP_ADDI:OP_SRAI]}) ? imm_reg : b_reg;
        is_alu = op_reg <= OP_SRAI;
        case (op_t'(op_reg))
            OP_ADDI: alu_op = 4'd0;
            OP_SLTI: alu_op = 4'd3;
            OP_SLTIU: alu_op = 4'd4;
            OP_XORI: alu_op = 4'd5;
            OP_ORI: alu_op = 4'd8;
            OP_ANDI: alu_op = 4'd9;
            OP_SLLI: alu_op = 4'd2;
            OP_SRLI: alu_op = 4'd6;
            OP_SRAI: alu_op = 4'd7;
            default: alu_op = op_reg[3:0];
        endcase
        add_v = a_reg + opb;
        lts = $signed(a_reg) < $signed(opb);
        ltu = a_reg < opb;
        case (alu_op)
            4'd0: alu_v = add_v;
            4'd1: alu_v = a_reg - opb;
            4'd2: alu_v = a_reg << opb[4:0];
            4'd3: alu_v = {31'd0, lts};
            4'd4: alu_v = {31'd0, ltu};
            4'd5: alu_v = a_reg ^ opb;
            4'd6: alu_v = a_reg >> opb[4:0];
            4'd7: alu_v = $unsigned($signed(a_reg) >>> opb[4:0]);
            4'd8: alu_v = a_reg | opb;
            default: alu_v = a_reg & opb;
        endcase
        seq = pc_reg + 32'd4;
        case (op_t'(op_reg))
            OP_BEQ: cond = a_reg == b_reg;
            OP_BNE: cond = a_reg != b_reg;
            OP_BLT: cond = lts;
            OP_BGE: cond = !lts;
            OP_BLTU: cond = ltu;
            OP_BGEU: cond = !ltu;
            default: cond = 1'b0;
        endcase
    end

    // Muldiv setup: signed flags per operation.
    logic        s_a, s_b, is_div, is_rem;
    assign is_div = op_reg >= OP_DIV;
    assign is_rem = (op_reg == OP_REM) || (op_reg == OP_REMU);
    assign s_a = (op_reg == OP_MULH) || (op_reg == OP_MULHSU) ||
                 (op_reg == OP_DIV) || (op_reg == OP_REM);
    assign s_b = (op_reg == OP_MULH) || (op_reg == OP_DIV) || (op_reg == OP_REM);

    // Shared 33-bit unit: trial subtract for divide, conditional add for multiply.
    logic [32:0] au_a, au_b, au_res;
    assign au_a   = is_div ? acc_reg[63:31] : {1'b0, acc_reg[63:32]};
    assign au_b   = (is_div || acc_reg[0]) ? {1'b0, mb_reg} : 33'd0;
    assign au_res = is_div ? (au_a - au_b) : (au_a + au_b);

    logic [31:0] abs_a, abs_b;
    assign abs_a = (s_a && a_reg[31]) ? -a_reg : a_reg;
    assign abs_b = (s_b && b_reg[31]) ? -b_reg : b_reg;

    logic [63:0] fixed;
    assign fixed = neg_reg ? -acc_reg : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg <= '0;
            pc_reg     <= '0;
            rd_b_reg   <= 1'b0;
        end else begin
            if (rf_we && rd_reg != '0) rf_vld_reg[rd_reg] <= 1'b1;
            if (cfg_wr_en) pc_reg <= cfg_wr_data;
            else if (state_reg == ST_OUT && m_tready) pc_reg <= npc_reg;
            if (state_reg == ST_READ) rd_b_reg <= !rd_b_reg;
        end
        case (state_reg)
            ST_IDLE: begin
                op_reg    <= s_tdata[5:0];
                rd_reg    <= s_tdata[10:6];
                a_idx_reg <= s_tdata[15:11];
                rs2_reg   <= s_tdata[20:16];
                imm_reg   <= s_tdata[52:21];
            end
            ST_READ: begin
                if (rd_is_a) a_reg <= rf_val;
                else         b_reg <= rf_val;
            end
            ST_EXEC: begin
                val_reg   <= 32'd0;
                npc_reg   <= seq;
                taken_reg <= 1'b0;
                wdone_reg <= (rd_reg != '0) && (op_reg <= OP_REMU) &&
                             !(op_reg inside {[OP_BEQ:OP_BGEU]});
                if (is_alu) val_reg <= alu_v;
                case (op_t'(op_reg))
                    OP_LUI: val_reg <= {imm_reg[19:0], 12'd0};
                    OP_AUIPC: val_reg <= pc_reg + {imm_reg[19:0], 12'd0};
                    OP_JAL: begin
                        val_reg <= seq; npc_reg <= pc_reg + imm_reg; taken_reg <= 1'b1;
                    end
                    OP_JALR: begin
                        val_reg <= seq; taken_reg <= 1'b1;
                        npc_reg <= (a_reg + imm_reg) & 32'hFFFF_FFFE;
                    end
                    default: begin
                        if (cond) begin
                            npc_reg <= pc_reg + imm_reg; taken_reg <= 1'b1;
                        end
                    end
                endcase
                cnt_reg <= '0;
                sa_reg  <= s_a && a_reg[31];
                sb_reg  <= s_b && b_reg[31];
                mb_reg  <= abs_b;
                acc_reg <= {32'd0, abs_a};
            end
            ST_ITER: begin
                cnt_reg <= cnt_reg + 6'd1;
                if (is_div) begin
                    if (!au_res[32]) acc_reg <= {au_res[31:0], acc_reg[30:0], 1'b1};
                    else             acc_reg <= {acc_reg[62:0], 1'b0};
                end else begin
                    // Shift-add, multiplier bits from the bottom.
                    acc_reg <= {au_res, acc_reg[31:1]};
                end
                neg_reg <= is_rem ? sa_reg : (sa_reg ^ sb_reg);
            end
            ST_FIX: begin
                if (is_div) begin
                    if (b_reg == '0) val_reg <= is_rem ? a_reg : 32'hFFFF_FFFF;
                    else if (is_rem)
                        val_reg <= neg_reg ? -acc_reg[63:32] : acc_reg[63:32];
                    else val_reg <= neg_reg ? -acc_reg[31:0] : acc_reg[31:0];
                end else if (op_reg == OP_MUL) val_reg <= fixed[31:0];
                else val_reg <= fixed[63:32];
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, taken_reg, npc_reg, wdone_reg, val_reg};

endmodule
